// ===== rtl/dhcp_lease_table_engine_unit_assert.svh =====
// assertion macros for the lease table engine
// used by the top level only, no other dependencies
`ifndef DHCP_LEASE_TABLE_ENGINE_UNIT_ASSERT_SVH
`define DHCP_LEASE_TABLE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define DLTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlte same-cycle check failed");

// next-cycle implication, disabled while reset is held
`define DLTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlte next-cycle check failed");

`endif

// ===== rtl/dlte_pkg.sv =====
// shared types and constants for the lease table engine
// no dependencies
package dlte_pkg;

  // reply codes on the result stream
  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_OFFER = 3'd1,
    KIND_ACK   = 3'd2,
    KIND_NAK   = 3'd3,
    KIND_BARE  = 3'd4
  } kind_t;

  // message types on the input stream
  localparam logic [1:0] REQ_DISCOVER = 2'd0;
  localparam logic [1:0] REQ_REQUEST  = 2'd1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_POOL_FIRST = 2'd0,
    REG_POOL_SIZE  = 2'd1,
    REG_SERVER     = 2'd2,
    REG_LEASE_FULL = 2'd3
  } cfg_reg_t;

  localparam logic [7:0]  RST_POOL_FIRST = 8'd2;
  localparam logic [5:0]  RST_POOL_SIZE  = 6'd32;
  localparam logic [7:0]  RST_SERVER     = 8'd1;
  localparam logic [31:0] RST_LEASE_FULL = 32'd900;

  localparam logic [31:0] HOLD_SECONDS = 32'd30;
  localparam logic [7:0]  OCTET_BCAST  = 8'd255;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] expiry;
  } slot_entry_t;

  typedef struct packed {
    logic [7:0]  pool_first;
    logic [5:0]  pool_size;
    logic [7:0]  server;
    logic [31:0] lease_full;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_PICKW,
    ST_EXEC
  } state_t;

endpackage

// ===== rtl/dlte_slot_mem.sv =====
// lease slot memory: mac and expiry per slot, one write and one read port
// registered read data, per-slot valid bits so empty slots read as zero
// depends on dlte_pkg
module dlte_slot_mem #(
  parameter int MAX_SLOTS = 32,
  parameter int SLOT_W    = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [SLOT_W-1:0]     rd_addr,
  output dlte_pkg::slot_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [SLOT_W-1:0]     wr_addr,
  input  dlte_pkg::slot_entry_t wr_data
);

  dlte_pkg::slot_entry_t mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]  vld_r;
  dlte_pkg::slot_entry_t q_r;
  logic                  q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  // never-written slot reads as empty
  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== rtl/dlte_ctrl.sv =====
// lease engine sequencer: slot scan, requested-slot check, update and result register
// drives dlte_slot_mem; depends on dlte_pkg
module dlte_ctrl #(
  parameter int MAX_SLOTS = 32,
  parameter int SLOT_W    = 5,
  parameter int CNT_W     = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dlte_pkg::cfg_t        cfg,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_req_type,
  input  logic [47:0]           in_client_mac,
  input  logic                  in_has_requested,
  input  logic [7:0]            in_requested_octet,
  input  logic                  in_has_server_id,
  input  logic [7:0]            in_server_id_octet,
  input  logic [31:0]           in_now_seconds,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output dlte_pkg::kind_t       out_reply_kind,
  output logic [7:0]            out_client_octet,
  output logic signed [31:0]    out_lease_left,
  output logic                  mem_rd_en,
  output logic [SLOT_W-1:0]     mem_rd_addr,
  input  dlte_pkg::slot_entry_t mem_rd_data,
  output logic                  mem_wr_en,
  output logic [SLOT_W-1:0]     mem_wr_addr,
  output dlte_pkg::slot_entry_t mem_wr_data
);

  dlte_pkg::state_t state_r, state_nxt;

  logic [1:0]  type_r;
  logic [47:0] mac_r;
  logic        has_req_r;
  logic [7:0]  req_oct_r;
  logic        has_sid_r;
  logic [7:0]  sid_r;
  logic [31:0] now_r;

  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [SLOT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic              hit_r, hit_nxt;
  logic [SLOT_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [31:0]       hit_exp_r, hit_exp_nxt;
  logic              emp_r, emp_nxt;
  logic [SLOT_W-1:0] emp_idx_r, emp_idx_nxt;
  logic [31:0]       emp_exp_r, emp_exp_nxt;
  logic              use_off_r, use_off_nxt;

  logic                   out_valid_r, out_valid_nxt;
  dlte_pkg::kind_t        out_kind_r, out_kind_nxt;
  logic [7:0]             out_oct_r, out_oct_nxt;
  logic signed [31:0]     out_left_r, out_left_nxt;

  logic [7:0]        n8;
  logic [CNT_W-1:0]  n_slots;
  logic [7:0]        off8;
  logic              in_acc;
  logic [SLOT_W-1:0] sel_idx;
  logic [47:0]       sel_mac;
  logic [31:0]       sel_exp;
  logic [7:0]        octet;
  logic              req_ok;

  // slots in use: pool size capped at the table depth
  assign n8 = ({2'b00, cfg.pool_size} < 8'(MAX_SLOTS)) ? {2'b00, cfg.pool_size}
                                                      : 8'(MAX_SLOTS);
  assign n_slots = n8[CNT_W-1:0];
  assign off8    = req_oct_r - cfg.pool_first;
  assign in_acc  = in_tvalid && in_tready;

  assign sel_idx = use_off_r ? off8[SLOT_W-1:0] : (hit_r ? hit_idx_r : emp_idx_r);
  assign sel_mac = hit_r ? mac_r : '0;
  assign sel_exp = hit_r ? hit_exp_r : emp_exp_r;
  assign octet   = 8'(sel_idx) + cfg.pool_first;
  assign req_ok  = !(has_req_r && (req_oct_r != octet) && (sel_mac != '0)) &&
                   !(has_sid_r && (sid_r != cfg.server));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dlte_pkg::ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      type_r    <= in_req_type;
      mac_r     <= in_client_mac;
      has_req_r <= in_has_requested;
      req_oct_r <= in_requested_octet;
      has_sid_r <= in_has_server_id;
      sid_r     <= in_server_id_octet;
      now_r     <= in_now_seconds;
    end
    scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_exp_r  <= hit_exp_nxt;
    emp_r      <= emp_nxt;
    emp_idx_r  <= emp_idx_nxt;
    emp_exp_r  <= emp_exp_nxt;
    use_off_r  <= use_off_nxt;
    out_kind_r <= out_kind_nxt;
    out_oct_r  <= out_oct_nxt;
    out_left_r <= out_left_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_exp_nxt   = hit_exp_r;
    emp_nxt       = emp_r;
    emp_idx_nxt   = emp_idx_r;
    emp_exp_nxt   = emp_exp_r;
    use_off_nxt   = use_off_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_oct_nxt   = out_oct_r;
    out_left_nxt  = out_left_r;
    in_tready     = 1'b0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = sel_idx;
    mem_wr_data   = '0;

    // first mac match and first empty slot come out of one pass
    if (rd_pend_r && state_r == dlte_pkg::ST_SCAN) begin
      if (!hit_r && mem_rd_data.mac == mac_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = rd_idx_r;
        hit_exp_nxt = mem_rd_data.expiry;
      end
      if (!emp_r && mem_rd_data.mac == '0) begin
        emp_nxt     = 1'b1;
        emp_idx_nxt = rd_idx_r;
        emp_exp_nxt = mem_rd_data.expiry;
      end
    end

    unique case (state_r)
      dlte_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          scan_cnt_nxt = '0;
          hit_nxt      = 1'b0;
          emp_nxt      = 1'b0;
          use_off_nxt  = 1'b0;
          state_nxt    = dlte_pkg::ST_SCAN;
        end
      end
      dlte_pkg::ST_SCAN: begin
        if (scan_cnt_r != n_slots) begin
          mem_rd_en    = 1'b1;
          mem_rd_addr  = scan_cnt_r[SLOT_W-1:0];
          rd_idx_nxt   = scan_cnt_r[SLOT_W-1:0];
          rd_pend_nxt  = 1'b1;
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end else begin
          state_nxt = dlte_pkg::ST_PICK;
        end
      end
      dlte_pkg::ST_PICK: begin
        // discover asking for a slot in the pool: check that slot is free
        if (type_r == dlte_pkg::REQ_DISCOVER && has_req_r && off8 < n8 &&
            (hit_r || emp_r)) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = off8[SLOT_W-1:0];
          rd_pend_nxt = 1'b1;
          state_nxt   = dlte_pkg::ST_PICKW;
        end else begin
          state_nxt = dlte_pkg::ST_EXEC;
        end
      end
      dlte_pkg::ST_PICKW: begin
        if (rd_pend_r && mem_rd_data.mac == '0) begin
          use_off_nxt = 1'b1;
        end
        state_nxt = dlte_pkg::ST_EXEC;
      end
      dlte_pkg::ST_EXEC: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = dlte_pkg::ST_IDLE;
          if (!hit_r && !emp_r) begin
            out_kind_nxt = dlte_pkg::KIND_NONE;
            out_oct_nxt  = '0;
            out_left_nxt = '0;
          end else begin
            out_oct_nxt = octet;
            if (type_r == dlte_pkg::REQ_DISCOVER) begin
              mem_wr_en    = 1'b1;
              mem_wr_data  = '{mac: mac_r, expiry: now_r + dlte_pkg::HOLD_SECONDS};
              out_kind_nxt = dlte_pkg::KIND_OFFER;
              out_left_nxt = dlte_pkg::HOLD_SECONDS;
            end else if (type_r == dlte_pkg::REQ_REQUEST) begin
              if (req_ok) begin
                mem_wr_en    = 1'b1;
                mem_wr_data  = '{mac: sel_mac, expiry: now_r + cfg.lease_full};
                out_kind_nxt = dlte_pkg::KIND_ACK;
                out_left_nxt = cfg.lease_full;
              end else begin
                out_kind_nxt = dlte_pkg::KIND_NAK;
                out_left_nxt = sel_exp - now_r;
              end
            end else begin
              out_kind_nxt = dlte_pkg::KIND_BARE;
              out_left_nxt = '0;
            end
            // broadcast octet reports the full lease instead
            if (out_kind_nxt != dlte_pkg::KIND_BARE && octet == dlte_pkg::OCTET_BCAST) begin
              out_left_nxt = cfg.lease_full;
            end
          end
        end
      end
      default: begin
        state_nxt = dlte_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid       = out_valid_r;
  assign out_reply_kind   = out_kind_r;
  assign out_client_octet = out_oct_r;
  assign out_lease_left   = out_left_r;

endmodule

// ===== rtl/dhcp_lease_table_engine_unit.sv =====
// lease table engine top: configuration registers, sequencer and slot memory
// depends on dlte_pkg, dlte_ctrl, dlte_slot_mem and the assertion macro header
// result registered after a lookup pass over n = min(pool_size, MAX_SLOTS) slots, a pick
// step, a check read when a discover names a pool address, and an exec step that stalls
// while a result is held; next input beat only after that; the pass walks one slot per cycle
// reset: config returns to defaults, all slots read empty at once (no clearing pass)
`include "dhcp_lease_table_engine_unit_assert.svh"
module dhcp_lease_table_engine_unit #(
  parameter int MAX_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[1:0], client_mac[49:2], has_requested[50], requested_octet[58:51],
  // has_server_id[59], server_id_octet[67:60], now_seconds[99:68], zero pad
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reply_kind[2:0], client_octet[10:3], lease_left[42:11], zero pad
  output logic [47:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);

  dlte_pkg::cfg_t        cfg_r;
  dlte_pkg::kind_t       reply_kind;
  logic [7:0]            client_octet;
  logic signed [31:0]    lease_left;
  logic                  mem_rd_en;
  logic [SLOT_W-1:0]     mem_rd_addr;
  dlte_pkg::slot_entry_t mem_rd_data;
  logic                  mem_wr_en;
  logic [SLOT_W-1:0]     mem_wr_addr;
  dlte_pkg::slot_entry_t mem_wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_first <= dlte_pkg::RST_POOL_FIRST;
      cfg_r.pool_size  <= dlte_pkg::RST_POOL_SIZE;
      cfg_r.server     <= dlte_pkg::RST_SERVER;
      cfg_r.lease_full <= dlte_pkg::RST_LEASE_FULL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (dlte_pkg::cfg_reg_t'(cfg_index))
        dlte_pkg::REG_POOL_FIRST: cfg_r.pool_first <= cfg_data[7:0];
        dlte_pkg::REG_POOL_SIZE:  cfg_r.pool_size  <= cfg_data[5:0];
        dlte_pkg::REG_SERVER:     cfg_r.server     <= cfg_data[7:0];
        dlte_pkg::REG_LEASE_FULL: cfg_r.lease_full <= cfg_data;
      endcase
    end
  end

  dlte_ctrl #(
    .MAX_SLOTS(MAX_SLOTS),
    .SLOT_W   (SLOT_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_req_type       (in_tdata[1:0]),
    .in_client_mac     (in_tdata[49:2]),
    .in_has_requested  (in_tdata[50]),
    .in_requested_octet(in_tdata[58:51]),
    .in_has_server_id  (in_tdata[59]),
    .in_server_id_octet(in_tdata[67:60]),
    .in_now_seconds    (in_tdata[99:68]),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_reply_kind    (reply_kind),
    .out_client_octet  (client_octet),
    .out_lease_left    (lease_left),
    .mem_rd_en         (mem_rd_en),
    .mem_rd_addr       (mem_rd_addr),
    .mem_rd_data       (mem_rd_data),
    .mem_wr_en         (mem_wr_en),
    .mem_wr_addr       (mem_wr_addr),
    .mem_wr_data       (mem_wr_data)
  );

  dlte_slot_mem #(
    .MAX_SLOTS(MAX_SLOTS),
    .SLOT_W   (SLOT_W)
  ) u_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data)
  );

  assign out_tdata = {5'b00000, lease_left, client_octet, reply_kind};

  // one item in flight: an accepted beat closes the input side
  `DLTE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // full table gives an all-zero result
  `DLTE_ASSERT_IMP(a_none_zero, clk, rst_n,
    out_tvalid && out_tdata[2:0] == dlte_pkg::KIND_NONE,
    out_tdata[10:3] == 8'd0 && out_tdata[42:11] == 32'd0)
  // bare reply carries no lease time
  `DLTE_ASSERT_IMP(a_bare_no_lease, clk, rst_n,
    out_tvalid && out_tdata[2:0] == dlte_pkg::KIND_BARE, out_tdata[42:11] == 32'd0)

endmodule
